[rtl/cstp_pkg.sv]
// Shared types and constants of the cue sheet track parser.
// Used by cstp_ctrl, cstp_dp and cue_sheet_track_parser.
package cstp_pkg;

    localparam int MaxTracks = 99;

    typedef enum logic [1:0] {
        KIND_TRACK = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TYPE_NONE  = 2'd0,
        TYPE_MODE1 = 2'd1,
        TYPE_MODE2 = 2'd2,
        TYPE_AUDIO = 2'd3
    } t_ttype;

    localparam logic [0:0] CFG_RAW   = 1'b0;
    localparam logic [0:0] CFG_AUDIO = 1'b1;

    // Record request from the controller to the datapath.
    typedef struct packed {
        logic   valid;
        t_kind  kind;
        logic [6:0] slot;
        logic [6:0] number;
        t_ttype ttype;
        logic [23:0] tf;
        logic [6:0] seen;
    } t_rec_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic busy;
    } t_dp_stat;

endpackage

[rtl/cstp_dp.sv]
// Datapath: sector size registers, frame address math and output queue.
// Depends on cstp_pkg.
module cstp_dp
    import cstp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  t_rec_cmd    i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_record_kind,
    output logic [6:0]  o_track_slot,
    output logic [6:0]  o_track_number,
    output logic [1:0]  o_track_type,
    output logic [11:0] o_sector_bytes,
    output logic [7:0]  o_start_minutes,
    output logic [7:0]  o_start_seconds,
    output logic [7:0]  o_start_frames,
    output logic [31:0] o_start_address,
    output logic [6:0]  o_tracks_seen,
    output logic        o_final_record
);
    logic [11:0] r_raw, r_audio;
    // Queue of two pending records plus the address math stages.
    t_rec_cmd r_q [2];
    logic [1:0] r_cnt;
    logic r_s1, r_s2;
    logic [13:0] r_ms;
    logic [31:0] r_addr;
    logic pop, push;
    t_rec_cmd head;

    assign head = r_q[0];
    assign pop = o_valid && !i_stall;
    assign push = i_cmd.valid;
    assign o_stat.busy = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= 12'd2352;
            r_audio <= 12'd2352;
            r_cnt <= 2'd0;
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RAW) r_raw <= i_cfg_data;
                else r_audio <= i_cfg_data;
            end
            // Address pipeline: minutes*60+seconds, then *75+frames-150.
            r_s1 <= (r_cnt != 2'd0) && !r_s1 && !r_s2;
            r_s2 <= r_s1 || (r_s2 && !pop);
            if (r_cnt != 2'd0 && !r_s1 && !r_s2) begin
                r_ms <= 14'(head.tf[7:0]) * 14'd60 + 14'(head.tf[15:8]);
            end
            if (r_s1) begin
                r_addr <= 32'(r_ms) * 32'd75 + 32'(head.tf[23:16]) - 32'd150;
            end
            if (pop) begin
                r_q[0] <= (push && r_cnt == 2'd1) ? i_cmd : r_q[1];
                if (push && r_cnt == 2'd2) r_q[1] <= i_cmd;
            end else if (push) begin
                if (r_cnt == 2'd0) r_q[0] <= i_cmd;
                else r_q[1] <= i_cmd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_valid = r_s2;
    assign o_record_kind = head.kind;
    assign o_track_slot = head.slot;
    assign o_track_number = head.number;
    assign o_track_type = head.ttype;
    always_comb begin
        unique case (head.ttype)
            TYPE_MODE1, TYPE_MODE2: o_sector_bytes = r_raw;
            TYPE_AUDIO:             o_sector_bytes = r_audio;
            default:                o_sector_bytes = 12'd0;
        endcase
    end
    assign o_start_minutes = head.tf[7:0];
    assign o_start_seconds = head.tf[15:8];
    assign o_start_frames = head.tf[23:16];
    assign o_start_address = (head.kind == KIND_START) ? r_addr : 32'd0;
    assign o_tracks_seen = head.seen;
    assign o_final_record = (head.kind == KIND_END);
endmodule

[rtl/cstp_ctrl.sv]
// Controller: per-byte line parser state machine that issues records.
// Depends on cstp_pkg.
module cstp_ctrl
    import cstp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  t_dp_stat   i_stat,
    output t_rec_cmd   o_cmd
);
    typedef enum logic [3:0] {
        PH_START, PH_KEY, PH_SKIP, PH_TNUM_BL, PH_TNUM, PH_TTAIL, PH_TTYPE_BL,
        PH_TTYPE, PH_TDONE, PH_INUM_BL, PH_INUM, PH_ITAIL, PH_TSTART,
        PH_TFIELD, PH_IDONE
    } t_phase;

    t_phase r_ph, n_ph;
    logic [2:0] r_pos, n_pos, r_cand, n_cand;
    logic [7:0] r_acc, n_acc;
    logic [23:0] r_tf, n_tf;
    logic [1:0] r_tfi, n_tfi;
    logic [6:0] r_pnum, n_pnum, r_total, n_total, r_lnum, n_lnum;
    t_ttype r_ptype, n_ptype, r_ltype, n_ltype;
    logic r_acc_line, n_acc_line;
    t_rec_cmd n_cmd, n_end;
    logic [1:0] r_hold;
    logic take;
    logic [7:0] c;

    function automatic logic [7:0] key_ch(input logic [0:0] w, input logic [2:0] p);
        logic [39:0] s;
        s = w ? "INDEX" : "TRACK";
        return (p < 3'd5) ? s[8*(3'd4-p) +: 8] : 8'd0;
    endfunction
    function automatic logic [7:0] typ_ch(input logic [1:0] w, input logic [2:0] p);
        logic [39:0] s;
        s = (w == 2'd0) ? "MODE1" : (w == 2'd1) ? "MODE2" : "AUDIO";
        return (p < 3'd5) ? s[8*(3'd4-p) +: 8] : 8'd0;
    endfunction
    function automatic logic [7:0] sat(input logic [7:0] a, input logic [7:0] d);
        logic [11:0] v;
        v = 12'(a) * 12'd10 + 12'(d - 8'h30);
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    // A byte is held off while a hold runs or the record queue drains.
    assign o_stall = i_stat.busy || (r_hold != 2'd0);
    assign take = i_valid && !o_stall;
    assign c = i_text_byte;

    always_comb begin
        logic blank, digit, last;
        logic [2:0] keep, cand, pos;
        logic [6:0] tot;
        t_phase ph;
        logic [6:0] lnum;
        t_ttype ltype;
        logic acc_line;
        logic [6:0] pnum;
        blank = (c == 8'h20) || (c == 8'h09);
        digit = (c >= 8'h30) && (c <= 8'h39);
        last = i_end_of_text;
        n_ph = r_ph; n_pos = r_pos; n_cand = r_cand; n_acc = r_acc; n_tf = r_tf;
        n_tfi = r_tfi; n_pnum = r_pnum; n_ptype = r_ptype; n_acc_line = r_acc_line;
        n_total = r_total; n_lnum = r_lnum; n_ltype = r_ltype;
        n_cmd = '0;
        keep = 3'd0; cand = r_cand; pos = r_pos;
        ph = r_ph; acc_line = r_acc_line; pnum = r_pnum;
        tot = r_total; lnum = r_lnum; ltype = r_ltype;
        if (c != 8'h0A) begin
            unique case (r_ph)
                PH_START, PH_KEY: begin
                    if (r_ph == PH_START) begin
                        pos = 3'd0;
                        cand = {1'b0, r_total != 7'd0, 1'b1};
                    end
                    if (!(r_ph == PH_START && (blank || c == 8'h0D))) begin
                        for (int i = 0; i < 2; i++)
                            if (cand[i] && pos < 3'd5 && key_ch(1'(i), pos) == c)
                                keep[i] = 1'b1;
                        n_cand = keep;
                        n_pos = pos + 3'd1;
                        n_ph = PH_KEY;
                        if (keep == 3'd0) n_ph = PH_SKIP;
                        else if (pos == 3'd4) begin
                            n_acc = 8'd0;
                            n_ph = keep[0] ? PH_TNUM_BL : PH_INUM_BL;
                        end
                    end
                end
                PH_TNUM_BL, PH_INUM_BL: begin
                    if (!blank) begin
                        if (digit) begin
                            n_acc = c - 8'h30;
                            n_ph = (r_ph == PH_TNUM_BL) ? PH_TNUM : PH_INUM;
                        end else n_ph = PH_SKIP;
                    end
                end
                PH_TNUM: begin
                    if (digit) n_acc = sat(r_acc, c);
                    else if (r_acc >= 8'd1 && r_acc <= 8'd99) begin
                        n_pnum = r_acc[6:0]; n_ptype = TYPE_NONE; n_acc_line = 1'b1;
                        n_ph = blank ? PH_TTYPE_BL : (c == 8'h0D ? PH_TDONE : PH_TTAIL);
                    end else n_ph = PH_SKIP;
                end
                PH_TTAIL: begin
                    if (blank) n_ph = PH_TTYPE_BL;
                    else if (c == 8'h0D) n_ph = PH_TDONE;
                end
                PH_TTYPE_BL, PH_TTYPE: begin
                    if (r_ph == PH_TTYPE_BL) begin pos = 3'd0; cand = 3'd7; end
                    if (!(r_ph == PH_TTYPE_BL && blank)) begin
                        for (int i = 0; i < 3; i++)
                            if (cand[i] && pos < 3'd5 && typ_ch(2'(i), pos) == c)
                                keep[i] = 1'b1;
                        n_cand = keep; n_pos = pos + 3'd1; n_ph = PH_TTYPE;
                        if (keep == 3'd0) n_ph = PH_TDONE;
                        else if (pos == 3'd4) begin
                            n_ptype = keep[0] ? TYPE_MODE1 : keep[1] ? TYPE_MODE2 : TYPE_AUDIO;
                            n_ph = PH_TDONE;
                        end
                    end
                end
                PH_INUM: begin
                    if (digit) n_acc = sat(r_acc, c);
                    else if (r_acc != 8'd1) n_ph = PH_SKIP;
                    else begin
                        n_acc_line = 1'b1; n_tf = 24'd0; n_tfi = 2'd0;
                        n_ph = blank ? PH_TSTART : PH_ITAIL;
                    end
                end
                PH_ITAIL: if (blank) n_ph = PH_TSTART;
                PH_TSTART: begin
                    if (!blank) begin
                        if (digit) begin
                            n_acc = c - 8'h30;
                            n_tf[8*r_tfi +: 8] = c - 8'h30;
                            n_ph = PH_TFIELD;
                        end else n_ph = PH_IDONE;
                    end
                end
                PH_TFIELD: begin
                    if (digit) begin
                        n_acc = sat(r_acc, c);
                        n_tf[8*r_tfi +: 8] = sat(r_acc, c);
                    end else if (c == 8'h3A && r_tfi < 2'd2) begin
                        n_tfi = r_tfi + 2'd1; n_ph = PH_TSTART;
                    end else n_ph = PH_IDONE;
                end
                default: ;
            endcase
        end
        // Line end: on a line feed, or on the last byte.
        if (c == 8'h0A || last) begin
            ph = (c == 8'h0A) ? r_ph : n_ph;
            acc_line = (c == 8'h0A) ? r_acc_line : n_acc_line;
            pnum = (c == 8'h0A) ? r_pnum : n_pnum;
            if (ph == PH_TNUM && r_acc >= 8'd1 && r_acc <= 8'd99 && c == 8'h0A) begin
                acc_line = 1'b1; pnum = r_acc[6:0];
                n_ptype = TYPE_NONE;
            end
            if (ph == PH_TNUM && c != 8'h0A && n_acc >= 8'd1 && n_acc <= 8'd99) begin
                acc_line = 1'b1; pnum = n_acc[6:0]; n_ptype = TYPE_NONE;
            end
            if (ph == PH_INUM && ((c == 8'h0A) ? r_acc : n_acc) == 8'd1) acc_line = 1'b1;
            tot = r_total; lnum = r_lnum; ltype = r_ltype;
            if (acc_line && ph >= PH_TNUM && ph <= PH_TDONE) begin
                if (r_total < 7'(MaxTracks)) begin
                    lnum = pnum;
                    ltype = (c == 8'h0A) ? r_ptype : n_ptype;
                    tot = r_total + 7'd1;
                    n_cmd.valid = 1'b1; n_cmd.kind = KIND_TRACK; n_cmd.slot = r_total;
                    n_cmd.number = lnum; n_cmd.ttype = ltype; n_cmd.seen = tot;
                end
            end else if (acc_line && ph >= PH_INUM && ph <= PH_IDONE && r_total != 7'd0) begin
                n_cmd.valid = 1'b1; n_cmd.kind = KIND_START; n_cmd.slot = r_total - 7'd1;
                n_cmd.number = r_lnum; n_cmd.ttype = r_ltype;
                n_cmd.tf = (c == 8'h0A) ? r_tf : n_tf;
                n_cmd.seen = r_total;
            end
            n_total = tot; n_lnum = lnum; n_ltype = ltype;
            n_ph = PH_START; n_pos = 3'd0; n_cand = 3'd7; n_acc = 8'd0; n_tf = 24'd0;
            n_tfi = 2'd0; n_pnum = 7'd0; n_ptype = TYPE_NONE; n_acc_line = 1'b0;
        end
        n_end = '0;
        n_end.valid = 1'b1;
        n_end.kind = KIND_END;
        n_end.seen = n_total;
    end

    t_rec_cmd r_end;
    logic r_end_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_START; r_pos <= 3'd0; r_cand <= 3'd7; r_acc <= 8'd0;
            r_tf <= 24'd0; r_tfi <= 2'd0; r_pnum <= 7'd0; r_ptype <= TYPE_NONE;
            r_acc_line <= 1'b0; r_total <= 7'd0; r_lnum <= 7'd0; r_ltype <= TYPE_NONE;
            r_hold <= 2'd0; r_end_pend <= 1'b0;
            o_cmd <= '0;
        end else begin
            // The end record follows in the cycle after the line's own record.
            r_end_pend <= take && i_end_of_text;
            if (take) o_cmd <= n_cmd;
            else if (r_end_pend) o_cmd <= r_end;
            else o_cmd <= '0;
            if (take && (n_cmd.valid || i_end_of_text)) r_hold <= 2'd2;
            else if (r_hold != 2'd0) r_hold <= r_hold - 2'd1;
            if (take) begin
                r_ph <= n_ph; r_pos <= n_pos; r_cand <= n_cand; r_acc <= n_acc;
                r_tf <= n_tf; r_tfi <= n_tfi; r_pnum <= n_pnum; r_ptype <= n_ptype;
                r_acc_line <= n_acc_line;
                r_total <= i_end_of_text ? 7'd0 : n_total;
                r_lnum <= i_end_of_text ? 7'd0 : n_lnum;
                r_ltype <= i_end_of_text ? TYPE_NONE : n_ltype;
            end
            if (take && i_end_of_text) r_end <= n_end;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> o_cmd.kind != KIND_TRACK || o_cmd.slot < 7'(MaxTracks))
        else $error("track slot beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= 7'(MaxTracks)) else $error("track count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_end_of_text |=> r_end_pend && o_stall)
        else $error("end record not queued");
endmodule

[rtl/cue_sheet_track_parser.sv]
// Top level of the cue sheet track parser: controller plus datapath.
// Depends on cstp_pkg, cstp_ctrl and cstp_dp.
//
//  channel  | handshake              | payload
//  text in  | i_valid / o_stall      | i_text_byte, i_end_of_text
//  records  | o_valid / i_stall      | o_record_kind .. o_final_record
//  config   | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A byte that ends no line emits no record. A byte that emits a record
// passes through issue, queue, two address stages (multiply by 60, then by 75)
// and the handover, and so does the end record of a last byte. Reset is
// synchronous and active low; sector sizes return to 2352. Output stall holds
// the record and, through the queue, the input.
module cue_sheet_track_parser
    import cstp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_record_kind,
    output logic [6:0]  o_track_slot,
    output logic [6:0]  o_track_number,
    output logic [1:0]  o_track_type,
    output logic [11:0] o_sector_bytes,
    output logic [7:0]  o_start_minutes,
    output logic [7:0]  o_start_seconds,
    output logic [7:0]  o_start_frames,
    output logic [31:0] o_start_address,
    output logic [6:0]  o_tracks_seen,
    output logic        o_final_record
);
    t_rec_cmd cmd;
    t_dp_stat stat;

    cstp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_text_byte, .i_end_of_text,
        .i_stat(stat), .o_cmd(cmd)
    );
    cstp_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_cmd(cmd), .o_stat(stat), .o_valid, .i_stall,
        .o_record_kind, .o_track_slot, .o_track_number, .o_track_type,
        .o_sector_bytes, .o_start_minutes, .o_start_seconds, .o_start_frames,
        .o_start_address, .o_tracks_seen, .o_final_record
    );
endmodule

[dv/cue_sheet_track_parser_test.sv]
// Self-checking testbench for cue_sheet_track_parser: streams cue sheet text
// and checks every record against a built-in parser model.
// Depends on cstp_pkg and the RTL of cue_sheet_track_parser.
`timescale 1ns / 1ps

module cue_sheet_track_parser_test;
    import cstp_pkg::*;

    localparam int CycleLimit = 600000;
    localparam byte LF = 8'h0A;
    localparam byte CR = 8'h0D;
    localparam byte TAB = 8'h09;
    localparam byte SPC = 8'h20;

    typedef enum int {
        P_START, P_KEY, P_SKIP,
        P_TNUM_BL, P_TNUM, P_TTAIL, P_TTYPE_BL, P_TTYPE, P_TDONE,
        P_INUM_BL, P_INUM, P_ITAIL, P_TSTART, P_TFIELD, P_IDONE
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  slot;
        logic [6:0]  number;
        t_ttype      ttype;
        logic [11:0] bytes;
        logic [7:0]  mins;
        logic [7:0]  secs;
        logic [7:0]  frames;
        logic [31:0] addr;
        logic [6:0]  seen;
        logic        fin;
    } t_record;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_record_kind;
    logic [6:0]  o_track_slot;
    logic [6:0]  o_track_number;
    logic [1:0]  o_track_type;
    logic [11:0] o_sector_bytes;
    logic [7:0]  o_start_minutes;
    logic [7:0]  o_start_seconds;
    logic [7:0]  o_start_frames;
    logic [31:0] o_start_address;
    logic [6:0]  o_tracks_seen;
    logic        o_final_record;

    cue_sheet_track_parser uut (.*);

    always #2 i_clk = ~i_clk;

    // Parser model state.
    t_phase      phase;
    logic [2:0]  word_pos;
    logic [2:0]  cands;
    logic [7:0]  acc;
    logic [23:0] tfields;
    logic [1:0]  tf_idx;
    logic [6:0]  pend_num;
    logic [1:0]  pend_type;
    logic        line_ok;
    logic [6:0]  total;
    logic [6:0]  last_num;
    logic [1:0]  last_type;
    logic [11:0] raw_size = 12'd2352;
    logic [11:0] audio_size = 12'd2352;

    t_record expected_records[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_gap_pct = 0;
    int      stall_pct = 0;
    int      bytes_sent = 0;

    function automatic bit is_blank(byte c);
        return c == SPC || c == TAB;
    endfunction

    function automatic bit is_digit(byte c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] add_digit(logic [7:0] a, byte c);
        int v;
        v = a * 10 + (c - "0");
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    // Narrows the keyword candidates by one byte; table 0 holds line keywords,
    // table 1 the track type words.
    function automatic logic [2:0] narrow_word(bit types, byte c);
        string   words[3];
        logic [2:0] keep;
        int      n;
        keep = '0;
        if (types) begin
            words = '{"MODE1", "MODE2", "AUDIO"};
            n = 3;
        end else begin
            words = '{"TRACK", "INDEX", ""};
            n = 2;
        end
        if (word_pos < 5)
            for (int i = 0; i < n; i++)
                if (cands[i] && words[i][word_pos] == c) keep[i] = 1'b1;
        cands = keep;
        word_pos = word_pos + 3'd1;
        return keep;
    endfunction

    function automatic logic [11:0] size_of(t_ttype t);
        if (t == TYPE_MODE1 || t == TYPE_MODE2) return raw_size;
        if (t == TYPE_AUDIO) return audio_size;
        return '0;
    endfunction

    function automatic void push_record(t_kind k, logic [6:0] slot, logic [6:0] num,
                                        logic [1:0] t, logic [23:0] tf,
                                        logic [31:0] addr, logic fin);
        t_record r;
        r.kind = k;
        r.slot = slot;
        r.number = num;
        r.ttype = t_ttype'(t);
        r.bytes = size_of(t_ttype'(t));
        r.mins = tf[7:0];
        r.secs = tf[15:8];
        r.frames = tf[23:16];
        r.addr = addr;
        r.seen = total;
        r.fin = fin;
        expected_records.push_back(r);
    endfunction

    function automatic void clear_line();
        phase = P_START;
        word_pos = '0;
        cands = 3'd7;
        acc = '0;
        tfields = '0;
        tf_idx = '0;
        pend_num = '0;
        pend_type = '0;
        line_ok = 1'b0;
    endfunction

    function automatic void clear_sheet();
        clear_line();
        total = '0;
        last_num = '0;
        last_type = '0;
    endfunction

    function automatic bit take_track_number();
        if (acc >= 1 && acc <= 99) begin
            pend_num = acc[6:0];
            pend_type = '0;
            line_ok = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void finish_line();
        logic [31:0] m, s, f;
        if (phase == P_TNUM) void'(take_track_number());
        if (phase == P_INUM && acc == 1) line_ok = 1'b1;
        if (line_ok) begin
            if (phase >= P_TNUM && phase <= P_TDONE) begin
                if (total < MaxTracks) begin
                    last_num = pend_num;
                    last_type = pend_type;
                    total = total + 7'd1;
                    push_record(KIND_TRACK, total - 7'd1, last_num, last_type, '0, '0, 1'b0);
                end
            end else if (phase >= P_INUM && phase <= P_IDONE && total > 0) begin
                m = tfields[7:0];
                s = tfields[15:8];
                f = tfields[23:16];
                push_record(KIND_START, total - 7'd1, last_num, last_type, tfields,
                            (m * 60 + s) * 75 + f - 32'd150, 1'b0);
            end
        end
        clear_line();
    endfunction

    function automatic void store_time();
        case (tf_idx)
            2'd0: tfields[7:0] = acc;
            2'd1: tfields[15:8] = acc;
            default: tfields[23:16] = acc;
        endcase
    endfunction

    function automatic void parse_byte(byte c);
        logic [2:0] keep;
        if (phase == P_START) begin
            if (is_blank(c) || c == CR) return;
            word_pos = '0;
            cands = {1'b0, total > 0, 1'b1};
            phase = P_KEY;
        end
        if (phase == P_TTYPE_BL) begin
            if (is_blank(c)) return;
            word_pos = '0;
            cands = 3'd7;
            phase = P_TTYPE;
        end
        case (phase)
            P_KEY: begin
                keep = narrow_word(1'b0, c);
                if (keep == 0) phase = P_SKIP;
                else if (word_pos == 5) begin
                    acc = '0;
                    phase = keep[0] ? P_TNUM_BL : P_INUM_BL;
                end
            end
            P_TNUM_BL, P_INUM_BL: begin
                if (!is_blank(c)) begin
                    if (is_digit(c)) begin
                        acc = c - "0";
                        phase = (phase == P_TNUM_BL) ? P_TNUM : P_INUM;
                    end else phase = P_SKIP;
                end
            end
            P_TNUM: begin
                if (is_digit(c)) acc = add_digit(acc, c);
                else if (!take_track_number()) phase = P_SKIP;
                else phase = is_blank(c) ? P_TTYPE_BL : (c == CR ? P_TDONE : P_TTAIL);
            end
            P_TTAIL: begin
                if (is_blank(c)) phase = P_TTYPE_BL;
                else if (c == CR) phase = P_TDONE;
            end
            P_TTYPE: begin
                keep = narrow_word(1'b1, c);
                if (keep == 0) phase = P_TDONE;
                else if (word_pos == 5) begin
                    pend_type = keep[0] ? 2'd1 : (keep[1] ? 2'd2 : 2'd3);
                    phase = P_TDONE;
                end
            end
            P_INUM: begin
                if (is_digit(c)) acc = add_digit(acc, c);
                else if (acc != 1) phase = P_SKIP;
                else begin
                    line_ok = 1'b1;
                    tfields = '0;
                    tf_idx = '0;
                    phase = is_blank(c) ? P_TSTART : P_ITAIL;
                end
            end
            P_ITAIL: if (is_blank(c)) phase = P_TSTART;
            P_TSTART: begin
                if (!is_blank(c)) begin
                    if (is_digit(c)) begin
                        acc = c - "0";
                        store_time();
                        phase = P_TFIELD;
                    end else phase = P_IDONE;
                end
            end
            P_TFIELD: begin
                if (is_digit(c)) begin
                    acc = add_digit(acc, c);
                    store_time();
                end else if (c == ":" && tf_idx < 2) begin
                    tf_idx = tf_idx + 2'd1;
                    phase = P_TSTART;
                end else phase = P_IDONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_records(byte c, bit last);
        if (c == LF) finish_line();
        else parse_byte(c);
        if (last) begin
            if (c != LF) finish_line();
            push_record(KIND_END, '0, '0, '0, '0, '0, 1'b1);
            clear_sheet();
        end
    endfunction

    // Sends one text byte and waits until the block takes it.
    task automatic send_byte(byte c, bit last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_text_byte <= c;
        i_end_of_text <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_records(c, last);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit last);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], last && i == s.len() - 1);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_records.size() != 0) @(posedge i_clk);
        // Bytes that end no line may still be in flight.
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_sizes(logic [11:0] raw, logic [11:0] audio);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_RAW;
        i_cfg_data <= raw;
        @(posedge i_clk);
        i_cfg_index <= CFG_AUDIO;
        i_cfg_data <= audio;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        raw_size = raw;
        audio_size = audio;
    endtask

    function automatic string blanks(int lo, int hi);
        string s;
        s = "";
        repeat ($urandom_range(hi, lo)) s = {s, ($urandom_range(1) ? " " : "\t")};
        return s;
    endfunction

    function automatic string digits(int lo, int hi);
        string s;
        s = "";
        repeat ($urandom_range(hi, lo)) s = {s, string'(byte'("0" + $urandom_range(9)))};
        return s;
    endfunction

    // One random line, mostly well formed with random content.
    function automatic string random_line();
        string s, words[7];
        words = '{"MODE1", "MODE2", "AUDIO", "MODE1/2352", "MODE3", "AUD", "mode1"};
        s = blanks(0, 2);
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                s = {s, "TRACK", blanks(0, 2)};
                if ($urandom_range(9) < 7) s = {s, $sformatf("%02d", $urandom_range(99, 1))};
                else s = {s, digits(0, 4)};
                if ($urandom_range(7) == 0) s = {s, "x"};
                s = {s, blanks(0, 2)};
                if ($urandom_range(7) != 0) s = {s, words[$urandom_range(6)]};
            end
            4, 5, 6: begin
                s = {s, "INDEX", blanks(0, 2)};
                s = {s, ($urandom_range(3) != 0) ? "01" : digits(0, 3), blanks(0, 2)};
                s = {s, digits(1, 3), blanks(0, 1), ":", blanks(0, 1), digits(0, 3)};
                if ($urandom_range(5) != 0) s = {s, ":", digits(0, 3)};
                if ($urandom_range(7) == 0) s = {s, ":", digits(1, 2)};
            end
            7: s = {s, "FILE \"disc.bin\" BINARY"};
            8: repeat ($urandom_range(10, 1)) s = {s, string'(byte'($urandom_range(255)))};
            default: s = {s, ($urandom_range(1) ? "TRACE" : "INDEK"), " 01 00:00:00"};
        endcase
        if ($urandom_range(1)) s = {s, "\015"};
        return {s, "\n"};
    endfunction

    task automatic test_directed_sheet();
        send_text("INDEX 01 00:02:00\n", 1'b0);
        send_text("  \tTRACK 01 MODE1/2352\015\n", 1'b0);
        send_text("\tINDEX 01 00:00:00\015\n", 1'b0);
        send_text("TRACK 2\tAUDIO\n INDEX 01 255:300:99\n", 1'b0);
        send_text("TRACK 99 MODE2\nINDEX 1 1 : 2\nINDEX 00 00:02:00\n", 1'b0);
        send_text("TRACK 0 AUDIO\nTRACK 100 AUDIO\nTRACK -3 AUDIO\nTRACK 5\n", 1'b0);
        send_text("TRACK 06x AUDIO\nTRACK 07\015AUDIO\nTRACK 08 XYZZY\n", 1'b0);
        send_text("FILE \"a b.bin\" BINARY\n\n\015\nINDEX 01 99:59:74", 1'b1);
        send_text("\n", 1'b1);
        send_text({"TRACK 3 AUDIO\nINDEX 01 1:2:3:4", "\377\000"}, 1'b1);
    endtask

    task automatic test_track_capacity();
        for (int i = 0; i < 101; i++) send_text("TRACK 7\n", 1'b0);
        send_text("INDEX 01 70:00:00\n", 1'b1);
    endtask

    task automatic test_random_sheets(int count);
        string s;
        int    stop;
        stop = bytes_sent + count;
        while (bytes_sent < stop) begin
            s = random_line();
            // An occasional sheet end, sometimes in the middle of a line.
            if ($urandom_range(29) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
            send_text(s, s[s.len() - 1] != LF || $urandom_range(29) == 0);
        end
        send_text("\n", 1'b1);
    endtask

    task automatic test_idle_patterns();
        write_sizes(12'd0, 12'd4095);
        send_gap_pct = 6;
        stall_pct = 63;
        test_random_sheets(130);
        write_sizes(12'd4095, 12'd0);
        send_gap_pct = 63;
        stall_pct = 6;
        test_random_sheets(130);
        write_sizes(12'($urandom_range(4095)), 12'($urandom_range(4095)));
        send_gap_pct = 0;
        stall_pct = 0;
        test_random_sheets(130);
    endtask

    always @(posedge i_clk) begin
        i_stall <= $urandom_range(99) < stall_pct;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("cue_sheet_track_parser regression: fail");
            $finish;
        end
    end

    // Compares each taken record with the oldest expected one.
    always @(posedge i_clk) begin
        t_record got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_record_kind, o_track_slot, o_track_number, o_track_type,
                   o_sector_bytes, o_start_minutes, o_start_seconds, o_start_frames,
                   o_start_address, o_tracks_seen, o_final_record};
            if (expected_records.size() == 0) begin
                $display("%0t: record with none expected: %p", $time, got);
                errors++;
            end else begin
                want = expected_records.pop_front();
                if (got !== want) begin
                    $display("%0t: record mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_RAW;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_text_byte <= '0;
        i_end_of_text <= 1'b0;
        clear_sheet();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sheet();
        test_track_capacity();
        test_idle_patterns();
        wait_idle();
        if (errors == 0)
            $display("cue_sheet_track_parser regression: pass");
        else
            $display("cue_sheet_track_parser regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/cstp_pkg.sv
rtl/cstp_dp.sv
rtl/cstp_ctrl.sv
rtl/cue_sheet_track_parser.sv
dv/cue_sheet_track_parser_test.sv
